// File: rtl/core/zoned_page_frame_allocator_defines.svh
// Assertion macros for the zoned page frame allocator.
`ifndef ZONED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define ZONED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ZPFA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ZPFA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ZPFA_ASSERT_ALWAYS(lbl, cond, msg)
`define ZPFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/zpfa_pkg.sv
// Shared types and constants of the zoned page frame allocator.
package zpfa_pkg;

    localparam int FRAME_W = 36;
    localparam int REG_W   = 37;
    localparam int CNT_W   = 17;
    localparam int DESC_W  = 16;

    localparam int DEF_MAX_FRAMES = 65536;
    localparam int DEF_MAX_RANGES = 16;

    localparam logic [REG_W-1:0] RST_LOW_START = 37'd256;
    localparam logic [REG_W-1:0] RST_LOW_END   = 37'd262144;
    localparam logic [REG_W-1:0] RST_ANY_END   = 37'h10_0000_0000;
    localparam logic [REG_W-1:0] RST_KERN_END  = 37'd0;

    typedef enum logic [1:0] {
        OP_ADD_RUN = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NONE_FREE  = 3'd1,
        STS_DOUBLE     = 3'd2,
        STS_NOT_MAPPED = 3'd3,
        STS_TABLE_FULL = 3'd4,
        STS_RANGE_FULL = 3'd5,
        STS_REFUSED    = 3'd6,
        STS_UNKNOWN    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        REG_LOW_START = 2'd0,
        REG_LOW_END   = 2'd1,
        REG_ANY_END   = 2'd2,
        REG_KERN_END  = 2'd3
    } t_reg_idx;

endpackage

// File: rtl/core/zpfa_desc_mem.sv
// Descriptor table: frame, zone, free flag and free-list link per descriptor.
module zpfa_desc_mem #(
    parameter int DEPTH = zpfa_pkg::DEF_MAX_FRAMES,
    parameter int AW    = 16,
    parameter int LW    = 17
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [zpfa_pkg::FRAME_W-1:0] i_wframe,
    input  logic                         i_wzone,
    input  logic                         i_wfree,
    input  logic [LW-1:0]                i_wlink,
    input  logic [AW-1:0]                i_raddr,
    output logic [zpfa_pkg::FRAME_W-1:0] o_rframe,
    output logic                         o_rzone,
    output logic                         o_rfree,
    output logic [LW-1:0]                o_rlink
);
    localparam int EW = zpfa_pkg::FRAME_W + 2 + LW;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wframe, i_wzone, i_wfree, i_wlink};
        end
        r_rd <= mem[i_raddr];
    end

    assign {o_rframe, o_rzone, o_rfree, o_rlink} = r_rd;

endmodule

// File: rtl/core/zoned_page_frame_allocator.sv
// Top level of the zoned page frame allocator: sequencer, range map, zone lists.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    operation, zone_select, frame_number,
//                                           frame_count, descriptor_index
// result    out        o_valid / i_stall    status, descriptor_out, frame_out,
//                                           zone_out, zone_free_count
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Steps from accepted beat to result: alloc pops, reads, updates (popping again
// when the any zone falls back to the low zone); free checks, reads, updates;
// run add checks, then walks frame_count descriptors; lookup reads and compares
// per range entry scanned; error exits end sooner; idle precedes the next beat.
// The descriptor table has one registered read port; each visit costs a
// read wait. A run add writes one descriptor per cycle.
// Reset is synchronous, active low; the descriptor table and range map need
// no clearing pass since only entries below the fill counts are ever read.
// o_stall is high while an item is in work; a finished result sits in the
// output register until taken, and the next beat can be taken meanwhile.
`include "zoned_page_frame_allocator_defines.svh"

module zoned_page_frame_allocator #(
    parameter int MAX_FRAMES = zpfa_pkg::DEF_MAX_FRAMES,
    parameter int MAX_RANGES = zpfa_pkg::DEF_MAX_RANGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic        i_zone_select,
    input  logic [35:0] i_frame_number,
    input  logic [16:0] i_frame_count,
    input  logic [15:0] i_descriptor_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_descriptor_out,
    output logic [35:0] o_frame_out,
    output logic        o_zone_out,
    output logic [16:0] o_zone_free_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [36:0] i_cfg_data
);
    localparam int FW  = zpfa_pkg::FRAME_W;
    localparam int DW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int SW  = ((CW > 17) ? CW : 17) + 1;
    localparam int RW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int RCW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] NULL_LINK = CW'(MAX_FRAMES);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_AD_C1    = 15'h0002,
        S_AD_C2    = 15'h0004,
        S_AD_WALK  = 15'h0008,
        S_AL_POP   = 15'h0010,
        S_AL_RD    = 15'h0020,
        S_AL_UPD   = 15'h0040,
        S_FR_CHK   = 15'h0080,
        S_FR_RD    = 15'h0100,
        S_FR_UPD   = 15'h0200,
        S_LK_START = 15'h0400,
        S_LK_RD    = 15'h0800,
        S_LK_CMP   = 15'h1000,
        S_EM_WAIT  = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

    // control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_head [2];
    logic [CW-1:0]        n_head [2];
    logic [CW-1:0]        r_cnt [2];
    logic [CW-1:0]        n_cnt [2];
    logic [CW-1:0]        r_used, n_used;
    logic [RCW-1:0]       r_rused, n_rused;
    logic                 r_ov, n_ov;
    logic [36:0]          r_low_start, r_low_end, r_any_end, r_kern;

    // work registers
    logic                 r_z, n_z;
    logic [FW-1:0]        r_fr, n_fr;
    logic [16:0]          r_cntin, n_cntin;
    logic [15:0]          r_di, n_di;
    logic [37:0]          r_e, n_e;
    logic                 r_bad, n_bad;
    logic [37:0]          r_f, n_f;
    logic [16:0]          r_k, n_k;
    logic [DW-1:0]        r_d, n_d;
    logic [DW-1:0]        r_first, n_first;
    logic [DW-1:0]        r_raddr, n_raddr;
    logic [RCW-1:0]       r_i, n_i;
    logic [RW-1:0]        r_rng_addr, n_rng_addr;
    zpfa_pkg::t_status    r_status, n_status;

    // output register
    logic [2:0]           r_o_status;
    logic [15:0]          r_o_desc;
    logic [FW-1:0]        r_o_frame;
    logic                 r_o_zone;
    logic [16:0]          r_o_count;

    // descriptor table port
    logic                 d_we;
    logic [DW-1:0]        d_waddr;
    logic [FW-1:0]        d_wframe;
    logic                 d_wzone, d_wfree;
    logic [CW-1:0]        d_wlink;
    logic [FW-1:0]        rd_frame;
    logic                 rd_zone, rd_free;
    logic [CW-1:0]        rd_link;

    // range map
    logic [FW-1:0]        rng_base_mem  [MAX_RANGES];
    logic [16:0]          rng_len_mem   [MAX_RANGES];
    logic [DW-1:0]        rng_first_mem [MAX_RANGES];
    logic [FW-1:0]        rg_base;
    logic [16:0]          rg_len;
    logic [DW-1:0]        rg_first;
    logic                 rg_we;

    // datapath terms
    logic [37:0]          ad_sum;
    logic                 ad_fits, ad_full, ad_rfull;
    logic                 walk_z;
    logic [CW-1:0]        pop_h;
    logic                 pop_empty;
    logic [SW-1:0]        di_ext;
    logic [37:0]          lk_f, lk_b, lk_end;
    logic [16:0]          lk_off;
    logic [SW-1:0]        lk_d;
    logic                 lk_hit;
    logic                 out_load;
    logic                 err_out;
    logic [SW-1:0]        d_ext, cnt_ext;
    logic [CW:0]          cnt_sum;
    logic                 accept;

    zpfa_desc_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (DW),
        .LW    (CW)
    ) u_desc (
        .i_clk    (i_clk),
        .i_we     (d_we),
        .i_waddr  (d_waddr),
        .i_wframe (d_wframe),
        .i_wzone  (d_wzone),
        .i_wfree  (d_wfree),
        .i_wlink  (d_wlink),
        .i_raddr  (r_raddr),
        .o_rframe (rd_frame),
        .o_rzone  (rd_zone),
        .o_rfree  (rd_free),
        .o_rlink  (rd_link)
    );

    always_ff @(posedge i_clk) begin
        if (rg_we) begin
            rng_base_mem[r_rused[RW-1:0]]  <= r_fr;
            rng_len_mem[r_rused[RW-1:0]]   <= r_cntin;
            rng_first_mem[r_rused[RW-1:0]] <= DW'(r_used);
        end
        rg_base  <= rng_base_mem[r_rng_addr];
        rg_len   <= rng_len_mem[r_rng_addr];
        rg_first <= rng_first_mem[r_rng_addr];
    end

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // run add checks: end of run, zone fit, table and map space
    assign ad_sum   = 38'(r_fr) + 38'(r_cntin);
    assign ad_fits  = (r_e <= 38'(r_any_end))
                   || ((38'(r_fr) >= 38'(r_low_start)) && (r_e <= 38'(r_low_end)))
                   || ((r_low_start <= r_any_end) && (r_e <= 38'(r_low_end)));
    assign ad_full  = (SW'(r_used) + SW'(r_cntin)) > SW'(MAX_FRAMES);
    assign ad_rfull = r_rused >= RCW'(MAX_RANGES);
    // frame lands in the any zone unless it sits inside the low zone
    assign walk_z   = !((r_f >= 38'(r_low_start)) && (r_f < 38'(r_low_end)));

    assign pop_h     = r_head[r_z];
    assign pop_empty = (pop_h >= NULL_LINK) || (pop_h >= r_used);
    assign di_ext    = SW'(r_di);

    assign lk_f   = 38'(r_fr);
    assign lk_b   = 38'(rg_base);
    assign lk_end = lk_b + 38'(rg_len);
    assign lk_hit = (lk_f >= lk_b) && (lk_f < lk_end);
    assign lk_off = 17'(r_fr - rg_base);
    assign lk_d   = SW'(rg_first) + SW'(lk_off);

    assign out_load = (r_state == S_DONE) && (!r_ov || !i_stall);
    assign err_out  = (r_status != zpfa_pkg::STS_OK) && (r_status != zpfa_pkg::STS_DOUBLE);
    assign d_ext    = SW'(r_d);
    assign cnt_ext  = SW'(r_cnt[rd_zone]);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_rused    = r_rused;
        n_ov       = r_ov;
        n_z        = r_z;
        n_fr       = r_fr;
        n_cntin    = r_cntin;
        n_di       = r_di;
        n_e        = r_e;
        n_bad      = r_bad;
        n_f        = r_f;
        n_k        = r_k;
        n_d        = r_d;
        n_first    = r_first;
        n_raddr    = r_raddr;
        n_i        = r_i;
        n_rng_addr = r_rng_addr;
        n_status   = r_status;
        d_we       = 1'b0;
        d_waddr    = r_d;
        d_wframe   = rd_frame;
        d_wzone    = rd_zone;
        d_wfree    = rd_free;
        d_wlink    = rd_link;
        rg_we      = 1'b0;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_z     = i_zone_select;
                    n_fr    = i_frame_number;
                    n_cntin = i_frame_count;
                    n_di    = i_descriptor_index;
                    n_i     = '0;
                    unique case (zpfa_pkg::t_op'(i_operation))
                        zpfa_pkg::OP_ADD_RUN: n_state = S_AD_C1;
                        zpfa_pkg::OP_ALLOC:   n_state = S_AL_POP;
                        zpfa_pkg::OP_FREE:    n_state = S_FR_CHK;
                        zpfa_pkg::OP_LOOKUP:  n_state = S_LK_START;
                    endcase
                end
            end
            S_AD_C1: begin
                n_e     = ad_sum;
                n_bad   = (r_cntin == '0) || (37'(r_fr) < r_kern);
                n_state = S_AD_C2;
            end
            S_AD_C2: begin
                priority if (r_bad || !ad_fits) begin
                    n_status = zpfa_pkg::STS_REFUSED;
                    n_state  = S_DONE;
                end else if (ad_full) begin
                    n_status = zpfa_pkg::STS_TABLE_FULL;
                    n_state  = S_DONE;
                end else if (ad_rfull) begin
                    n_status = zpfa_pkg::STS_RANGE_FULL;
                    n_state  = S_DONE;
                end else begin
                    rg_we    = 1'b1;
                    n_rused  = r_rused + 1'b1;
                    n_f      = 38'(r_fr);
                    n_d      = DW'(r_used);
                    n_first  = DW'(r_used);
                    n_k      = r_cntin;
                    n_state  = S_AD_WALK;
                end
            end
            S_AD_WALK: begin
                // one descriptor per cycle, pushed onto its zone's list
                d_we          = 1'b1;
                d_waddr       = r_d;
                d_wframe      = r_f[FW-1:0];
                d_wzone       = walk_z;
                d_wfree       = 1'b1;
                d_wlink       = r_head[walk_z];
                n_head[walk_z] = CW'(r_d);
                n_cnt[walk_z]  = r_cnt[walk_z] + 1'b1;
                n_used        = r_used + 1'b1;
                n_d           = r_d + 1'b1;
                n_f           = r_f + 1'b1;
                n_k           = r_k - 1'b1;
                if (r_k == 17'd1) begin
                    n_raddr  = r_first;
                    n_d      = r_first;
                    n_status = zpfa_pkg::STS_OK;
                    n_state  = S_EM_WAIT;
                end
            end
            S_AL_POP: begin
                if (pop_empty) begin
                    if (r_z) begin
                        n_z = 1'b0;       // any zone empty: fall back to low zone
                    end else begin
                        n_status = zpfa_pkg::STS_NONE_FREE;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_raddr = pop_h[DW-1:0];
                    n_d     = pop_h[DW-1:0];
                    n_state = S_AL_RD;
                end
            end
            S_AL_RD: begin
                n_state = S_AL_UPD;
            end
            S_AL_UPD: begin
                d_we        = 1'b1;
                d_wfree     = 1'b0;
                n_head[r_z] = rd_link;
                n_cnt[r_z]  = r_cnt[r_z] - 1'b1;
                n_status    = zpfa_pkg::STS_OK;
                n_state     = S_EM_WAIT;
            end
            S_FR_CHK: begin
                if (di_ext >= SW'(r_used)) begin
                    n_status = zpfa_pkg::STS_UNKNOWN;
                    n_state  = S_DONE;
                end else begin
                    n_raddr = di_ext[DW-1:0];
                    n_d     = di_ext[DW-1:0];
                    n_state = S_FR_RD;
                end
            end
            S_FR_RD: begin
                n_state = S_FR_UPD;
            end
            S_FR_UPD: begin
                if (rd_free) begin
                    n_status = zpfa_pkg::STS_DOUBLE;
                    n_state  = S_DONE;
                end else begin
                    d_we            = 1'b1;
                    d_wfree         = 1'b1;
                    d_wlink         = r_head[rd_zone];
                    n_head[rd_zone] = CW'(r_d);
                    n_cnt[rd_zone]  = r_cnt[rd_zone] + 1'b1;
                    n_status        = zpfa_pkg::STS_OK;
                    n_state         = S_EM_WAIT;
                end
            end
            S_LK_START: begin
                if (r_i >= r_rused) begin
                    n_status = zpfa_pkg::STS_NOT_MAPPED;
                    n_state  = S_DONE;
                end else begin
                    n_rng_addr = r_i[RW-1:0];
                    n_state    = S_LK_RD;
                end
            end
            S_LK_RD: begin
                n_state = S_LK_CMP;
            end
            S_LK_CMP: begin
                // first recorded run holding the frame answers
                priority if (!lk_hit) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_LK_START;
                end else if (lk_d >= SW'(r_used)) begin
                    n_status = zpfa_pkg::STS_NOT_MAPPED;
                    n_state  = S_DONE;
                end else begin
                    n_raddr  = lk_d[DW-1:0];
                    n_d      = lk_d[DW-1:0];
                    n_status = zpfa_pkg::STS_OK;
                    n_state  = S_EM_WAIT;
                end
            end
            S_EM_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head[0]   <= NULL_LINK;
            r_head[1]   <= NULL_LINK;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_used      <= '0;
            r_rused     <= '0;
            r_ov        <= 1'b0;
            r_low_start <= zpfa_pkg::RST_LOW_START;
            r_low_end   <= zpfa_pkg::RST_LOW_END;
            r_any_end   <= zpfa_pkg::RST_ANY_END;
            r_kern      <= zpfa_pkg::RST_KERN_END;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_rused <= n_rused;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (zpfa_pkg::t_reg_idx'(i_cfg_index))
                    zpfa_pkg::REG_LOW_START: r_low_start <= i_cfg_data;
                    zpfa_pkg::REG_LOW_END:   r_low_end   <= i_cfg_data;
                    zpfa_pkg::REG_ANY_END:   r_any_end   <= i_cfg_data;
                    zpfa_pkg::REG_KERN_END:  r_kern      <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_z        <= n_z;
        r_fr       <= n_fr;
        r_cntin    <= n_cntin;
        r_di       <= n_di;
        r_e        <= n_e;
        r_bad      <= n_bad;
        r_f        <= n_f;
        r_k        <= n_k;
        r_d        <= n_d;
        r_first    <= n_first;
        r_raddr    <= n_raddr;
        r_i        <= n_i;
        r_rng_addr <= n_rng_addr;
        r_status   <= n_status;
        if (out_load) begin
            r_o_status <= r_status;
            if (err_out) begin
                r_o_desc  <= '0;
                r_o_frame <= '0;
                r_o_zone  <= 1'b0;
                r_o_count <= '0;
            end else begin
                r_o_desc  <= d_ext[15:0];
                r_o_frame <= rd_frame;
                r_o_zone  <= rd_zone;
                r_o_count <= cnt_ext[16:0];
            end
        end
    end

    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_descriptor_out  = r_o_desc;
    assign o_frame_out       = r_o_frame;
    assign o_zone_out        = r_o_zone;
    assign o_zone_free_count = r_o_count;

    // free descriptors across both lists never outnumber those created
    assign cnt_sum = (CW + 1)'(r_cnt[0]) + (CW + 1)'(r_cnt[1]);

    `ZPFA_ASSERT_ALWAYS(a_free_le_used, cnt_sum <= (CW + 1)'(r_used), "free count exceeds table fill")
    `ZPFA_ASSERT_ALWAYS(a_ranges_le_max, r_rused <= RCW'(MAX_RANGES), "range map overfilled")
    `ZPFA_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE, "accepted beat not started")

endmodule
